/* hw/rtl/shs_pkg.sv */
`default_nettype none

package shs_pkg;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_CLOAD = 7'b0000100,
		ST_CPRE  = 7'b0001000,
		ST_ROUND = 7'b0010000,
		ST_FOLD  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic advance;
		logic from_mem;
	} sched_ctl_t;

	localparam logic       MODE_ABSORB = 1'b0;
	localparam logic       MODE_FINISH = 1'b1;
	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] LEN_OFFSET  = 6'd56;
	localparam logic [5:0] LAST_FILL   = 6'd63;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [5:0] MEM_ROUNDS  = 6'd15;
	localparam logic [2:0] LAST_INDEX  = 3'd7;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/shs_stream_if.sv */
`default_nettype none

interface shs_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/shs_sched.sv */
`default_nettype none

module shs_sched (
	input  logic                clk,
	input  shs_pkg::sched_ctl_t ctl,
	input  logic [31:0]         mem_word,
	output logic [31:0]         w
);
	import shs_pkg::*;

	logic [31:0] win_q [16];
	logic [31:0] next_word;

	// taps: [15] newest word, [0] sixteen words back
	always_comb begin
		if (ctl.from_mem) begin
			next_word = mem_word;
		end else begin
			next_word = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= next_word;
		end
	end

	assign w = win_q[15];

endmodule

`default_nettype wire

/* hw/rtl/sha256_stream_hasher.sv */
// channel  dir  payload                                   transfer
// msg      in   mode, data_byte                           valid && ready
// dig      out  digest_word, word_index, last_word        valid && ready
//
// the byte that fills a block starts a compression (load, prefetch, rounds at one
// round per cycle, fold); the block memory feeds the first sixteen words
// a finish writes one padding byte per cycle up to the end of the block, runs one or
// two compressions, then presents the eight digest words one per transfer
// msg.ready is high only while idle; dig stalls simply hold the current word
// reset restores the initial hash values and clears the length and fill count
`default_nettype none

module sha256_stream_hasher (
	input  logic      clk,
	input  logic      arst_n,
	shs_in_if.sink    msg,
	shs_out_if.source dig
);
	import shs_pkg::*;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bit_len_q;
	logic        fin_q;
	logic        mark_q;
	logic        len_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic [31:0] chain_q [8];
	logic [31:0] var_q [8];

	logic [31:0] blk_mem [16];
	logic [31:0] rd_word_q;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [7:0]  pad_byte;

	sched_ctl_t  sch_ctl;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        msg_xfer;
	logic        dig_xfer;

	assign msg.ready = (state_q == ST_IDLE);
	assign msg_xfer  = msg.valid & msg.ready;
	assign dig_xfer  = dig.valid & dig.ready;

	assign dig.valid       = (state_q == ST_EMIT);
	assign dig.digest_word = chain_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == LAST_INDEX);

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_q || fill_q == LEN_OFFSET) begin
			pad_byte = bit_len_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign wr_en   = (msg_xfer && msg.mode == MODE_ABSORB) || state_q == ST_PAD;
	assign wr_byte = (state_q == ST_PAD) ? pad_byte : msg.data_byte;

	always_comb begin
		if (state_q == ST_CLOAD) begin
			rd_addr = 4'd0;
		end else if (state_q == ST_CPRE) begin
			rd_addr = 4'd1;
		end else begin
			rd_addr = round_q[3:0] + 4'd2;
		end
	end

	// big-endian byte lanes
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (wr_en && fill_q[1:0] == 2'(k)) begin
				blk_mem[fill_q[5:2]][8 * (3 - k) +: 8] <= wr_byte;
			end
		end
		rd_word_q <= blk_mem[rd_addr];
	end

	assign sch_ctl.advance  = (state_q == ST_CPRE) || (state_q == ST_ROUND);
	assign sch_ctl.from_mem = (state_q == ST_CPRE) ||
		(state_q == ST_ROUND && round_q < MEM_ROUNDS);

	shs_sched u_sched (
		.clk      (clk),
		.ctl      (sch_ctl),
		.mem_word (rd_word_q),
		.w        (w_cur)
	);

	assign t1 = var_q[7] + bsig1(var_q[4]) + ch(var_q[4], var_q[5], var_q[6]) +
		RC[round_q] + w_cur;
	assign t2 = bsig0(var_q[0]) + maj(var_q[0], var_q[1], var_q[2]);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLOAD) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			bit_len_q <= '0;
			fin_q     <= 1'b0;
			mark_q    <= 1'b0;
			len_q     <= 1'b0;
			round_q   <= '0;
			idx_q     <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_xfer) begin
						if (msg.mode == MODE_FINISH) begin
							fin_q   <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							fill_q    <= fill_q + 6'd1;
							bit_len_q <= bit_len_q + 64'd8;
							if (fill_q == LAST_FILL) begin
								state_q <= ST_CLOAD;
							end
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!mark_q) begin
						mark_q <= 1'b1;
					end else if (fill_q == LEN_OFFSET) begin
						len_q <= 1'b1;
					end
					if (fill_q == LAST_FILL) begin
						state_q <= ST_CLOAD;
					end
				end
				ST_CLOAD: begin
					round_q <= '0;
					state_q <= ST_CPRE;
				end
				ST_CPRE: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					idx_q <= '0;
					if (fin_q && len_q) begin
						state_q <= ST_EMIT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (dig_xfer) begin
						if (idx_q == LAST_INDEX) begin
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= H_INIT[i];
							end
							bit_len_q <= '0;
							fin_q     <= 1'b0;
							mark_q    <= 1'b0;
							len_q     <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_full_block_compresses: assert property (@(posedge clk) disable iff (!arst_n)
		msg_xfer && msg.mode == MODE_ABSORB && fill_q == LAST_FILL |=> state_q == ST_CLOAD)
		else $error("full block did not start compression");

	a_emit_after_padding: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> fin_q && mark_q && len_q && fill_q == 6'd0)
		else $error("digest presented before padding completed");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> round_q == 6'd0)
		else $error("round counter nonzero outside compression");

	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid && !dig.ready |=> dig.valid && $stable(idx_q))
		else $error("digest word index moved while stalled");

endmodule

`default_nettype wire
